// File: sv/pbpm_pkg.sv
`default_nettype none
package pbpm_pkg;

	// Pool geometry.
	localparam int SMALL_BYTES  = 256;
	localparam int LARGE_BYTES  = 2048;
	localparam int SMALL_COUNT  = 16;
	localparam int LARGE_COUNT  = 8;
	localparam int HEADER_BYTES = 32;
	localparam int FOOTER_BYTES = 4;

	// A slot number is four bits wide, so at most sixteen buffers per pool are reachable.
	localparam int SMALL_USE = (SMALL_COUNT > 16) ? 16 : SMALL_COUNT;
	localparam int LARGE_USE = (LARGE_COUNT > 16) ? 16 : LARGE_COUNT;
	localparam int CNT_W     = $clog2(LARGE_USE + 1);

	localparam logic [15:0] SMALL_MASK = 16'((32'd1 << SMALL_USE) - 32'd1);
	localparam logic [15:0] LARGE_MASK = 16'((32'd1 << LARGE_USE) - 32'd1);

	// Payload capacity of one buffer after the header.
	localparam int SMALL_CAP = (SMALL_BYTES > HEADER_BYTES) ? SMALL_BYTES - HEADER_BYTES : 0;
	localparam int LARGE_CAP = (LARGE_BYTES > HEADER_BYTES) ? LARGE_BYTES - HEADER_BYTES : 0;

	typedef enum logic [2:0] {
		MODE_ALLOC    = 3'd0,
		MODE_ADDREF   = 3'd1,
		MODE_RELEASE  = 3'd2,
		MODE_ADJUST   = 3'd3,
		MODE_SET_SIZE = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		OP_ALLOC,
		OP_ADDREF,
		OP_RELEASE,
		OP_TRIM,
		OP_GROW,
		OP_SET_SIZE,
		OP_NONE
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_BUF   = 2'd1,
		ST_HEADROOM = 2'd2,
		ST_CAPACITY = 2'd3
	} status_t;

	// One classified request as it waits in the queue.
	typedef struct packed {
		op_t         op;
		logic        pool;
		logic [3:0]  slot;
		logic        fits_small;
		logic        fits_large;
		logic [11:0] arg;        // request length, shift magnitude or target length
		logic [11:0] alloc_off;  // payload offset of a newly allocated buffer
	} cmd_t;

	typedef struct packed {
		status_t     status;
		logic        pool;
		logic [3:0]  slot;
		logic [11:0] data_offset;
		logic [11:0] data_len;
		logic [7:0]  ref_count;
		logic [3:0]  large_free;
	} res_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage
`default_nettype wire

// File: sv/pbpm_front.sv
`default_nettype none
module pbpm_front
	import pbpm_pkg::*;
(
	input  wire logic [2:0]  mode,
	input  wire logic        pool,
	input  wire logic [3:0]  slot,
	input  wire logic [11:0] request_len,
	input  wire logic [10:0] headroom,
	input  wire logic [11:0] shift_amount,
	input  wire logic [11:0] target_len,
	output cmd_t             cmd
);

	logic [13:0] small_need;
	logic        trim;

	// Total bytes an allocation takes in a small buffer.
	assign small_need = 14'(request_len) + 14'(headroom) + 14'(HEADER_BYTES) + 14'(FOOTER_BYTES);
	assign trim       = (shift_amount != 12'd0) && !shift_amount[11];

	always_comb begin
		cmd.pool       = pool;
		cmd.slot       = slot;
		cmd.fits_small = (small_need <= 14'(SMALL_BYTES));
		cmd.fits_large = (13'(request_len) <= 13'(LARGE_BYTES));
		cmd.alloc_off  = 12'(12'(headroom) + 12'(HEADER_BYTES));
		cmd.arg        = request_len;
		unique case (mode)
			MODE_ALLOC: begin
				cmd.op = OP_ALLOC;
			end
			MODE_ADDREF: begin
				cmd.op = OP_ADDREF;
			end
			MODE_RELEASE: begin
				cmd.op = OP_RELEASE;
			end
			MODE_ADJUST: begin
				// Growing carries the magnitude of the negative shift.
				cmd.op  = trim ? OP_TRIM : OP_GROW;
				cmd.arg = trim ? shift_amount : 12'(12'd0 - shift_amount);
			end
			MODE_SET_SIZE: begin
				cmd.op  = OP_SET_SIZE;
				cmd.arg = target_len;
			end
			default: begin
				cmd.op = OP_NONE;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: sv/pbpm_queue.sv
`default_nettype none
module pbpm_queue
	import pbpm_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	input  wire logic pop,
	output cmd_t      head_cmd,
	output q_stat_t   stat
);

	cmd_t       entry_q [0:1];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign stat.empty = (count_q == 2'd0);
	assign stat.full  = (count_q == 2'd2);
	assign head_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

// File: sv/pbpm_back.sv
`default_nettype none
module pbpm_back
	import pbpm_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire cmd_t    cmd,
	input  wire q_stat_t q_stat,
	output logic         pop,
	input  wire logic    out_stall,
	output logic         out_valid,
	output res_t         res
);

	typedef struct packed {
		logic       found;
		logic [3:0] idx;
	} pick_t;

	// Lowest set bit of a free mask.
	function automatic pick_t first_free(input logic [15:0] avail);
		pick_t r;
		r.found = 1'b0;
		r.idx   = 4'd0;
		for (int i = 15; i >= 0; i--) begin
			if (avail[i]) begin
				r.found = 1'b1;
				r.idx   = 4'(i);
			end
		end
		return r;
	endfunction

	logic [SMALL_USE-1:0] small_map_q;
	logic [LARGE_USE-1:0] large_map_q;
	logic [CNT_W-1:0]     large_cnt_q;

	logic [11:0] desc_off_q  [0:31];
	logic [11:0] desc_len_q  [0:31];
	logic [7:0]  desc_refs_q [0:31];

	logic        out_valid_q;
	res_t        res_q;

	logic [15:0] small_map16, large_map16;
	pick_t       small_pick, large_pick;
	logic [4:0]  rd_idx, wr_idx;
	logic [11:0] cur_off, cur_len;
	logic [7:0]  cur_refs;
	logic        buf_ok;

	logic        found;
	status_t     status;
	logic        res_pool;
	logic [3:0]  res_slot;
	logic [11:0] new_off, new_len;
	logic [7:0]  new_refs;
	logic        desc_we;
	logic        set_bit, clr_bit;
	logic [15:0] slot_bit;
	logic [CNT_W-1:0] cnt_next;
	logic [CNT_W:0]   free_w;

	logic [11:0] trim_d, off_room;
	logic [11:0] grow_room;
	logic [12:0] grow_len;
	logic [12:0] size_end;

	assign small_map16 = 16'(small_map_q);
	assign large_map16 = 16'(large_map_q);
	assign small_pick  = first_free(~small_map16 & SMALL_MASK);
	assign large_pick  = first_free(~large_map16 & LARGE_MASK);

	assign rd_idx   = {cmd.pool, cmd.slot};
	assign cur_off  = desc_off_q[rd_idx];
	assign cur_len  = desc_len_q[rd_idx];
	assign cur_refs = desc_refs_q[rd_idx];
	assign buf_ok   = cmd.pool ? large_map16[cmd.slot] : small_map16[cmd.slot];

	assign pop = !q_stat.empty && (!out_valid_q || !out_stall);

	assign off_room  = 12'hFFF - cur_off;
	assign grow_room = (cur_off > 12'(HEADER_BYTES)) ? 12'(cur_off - 12'(HEADER_BYTES)) : 12'd0;
	assign grow_len  = 13'(cur_len) + 13'(cmd.arg);
	assign size_end  = 13'(cur_off) + 13'(cmd.arg);

	always_comb begin
		trim_d = cmd.arg;
		if (trim_d > cur_len) begin
			trim_d = cur_len;
		end
		if (trim_d > off_room) begin
			trim_d = off_room;
		end
	end

	always_comb begin
		found    = 1'b0;
		status   = ST_OK;
		res_pool = cmd.pool;
		res_slot = cmd.slot;
		new_off  = cur_off;
		new_len  = cur_len;
		new_refs = cur_refs;
		desc_we  = 1'b0;
		set_bit  = 1'b0;
		clr_bit  = 1'b0;
		cnt_next = large_cnt_q;
		if (cmd.op == OP_ALLOC) begin
			if (cmd.fits_small && small_pick.found) begin
				found    = 1'b1;
				res_pool = 1'b0;
				res_slot = small_pick.idx;
			end else if (cmd.fits_large && large_pick.found) begin
				found    = 1'b1;
				res_pool = 1'b1;
				res_slot = large_pick.idx;
				cnt_next = large_cnt_q + CNT_W'(1);
			end
			set_bit  = found;
			desc_we  = found;
			new_off  = cmd.alloc_off;
			new_len  = cmd.arg;
			new_refs = 8'd1;
		end else if (cmd.op != OP_NONE && buf_ok) begin
			found = 1'b1;
			case (cmd.op)
				OP_ADDREF: begin
					desc_we = 1'b1;
					if (cur_refs != 8'hFF) begin
						new_refs = cur_refs + 8'd1;
					end
				end
				OP_RELEASE: begin
					desc_we = 1'b1;
					if (cur_refs != 8'd0) begin
						new_refs = cur_refs - 8'd1;
					end
					if (new_refs == 8'd0) begin
						clr_bit = 1'b1;
						if (cmd.pool && large_cnt_q != '0) begin
							cnt_next = large_cnt_q - CNT_W'(1);
						end
					end
				end
				OP_TRIM: begin
					desc_we = 1'b1;
					new_off = cur_off + trim_d;
					new_len = cur_len - trim_d;
				end
				OP_GROW: begin
					if (cmd.arg > grow_room) begin
						status = ST_HEADROOM;
					end else begin
						desc_we = 1'b1;
						new_off = cur_off - cmd.arg;
						new_len = grow_len[12] ? 12'hFFF : grow_len[11:0];
					end
				end
				default: begin
					// Set size.
					if (size_end > (cmd.pool ? 13'(LARGE_CAP) : 13'(SMALL_CAP))) begin
						status = ST_CAPACITY;
					end else begin
						desc_we = 1'b1;
						new_len = cmd.arg;
					end
				end
			endcase
		end
	end

	assign wr_idx   = {res_pool, res_slot};
	assign slot_bit = 16'd1 << res_slot;
	assign free_w   = (CNT_W + 1)'(LARGE_USE) - (CNT_W + 1)'(cnt_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			small_map_q <= '0;
			large_map_q <= '0;
			large_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				large_cnt_q <= cnt_next;
				if (set_bit || clr_bit) begin
					if (res_pool) begin
						large_map_q <= LARGE_USE'(set_bit ? (large_map16 | slot_bit)
							: (large_map16 & ~slot_bit));
					end else begin
						small_map_q <= SMALL_USE'(set_bit ? (small_map16 | slot_bit)
							: (small_map16 & ~slot_bit));
					end
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (desc_we) begin
				desc_off_q[wr_idx]  <= new_off;
				desc_len_q[wr_idx]  <= new_len;
				desc_refs_q[wr_idx] <= new_refs;
			end
			res_q.large_free <= (free_w > (CNT_W + 1)'(15)) ? 4'hF : free_w[3:0];
			if (found) begin
				res_q.status      <= status;
				res_q.pool        <= res_pool;
				res_q.slot        <= res_slot;
				res_q.data_offset <= new_off;
				res_q.data_len    <= new_len;
				res_q.ref_count   <= new_refs;
			end else begin
				res_q.status      <= ST_NO_BUF;
				res_q.pool        <= 1'b0;
				res_q.slot        <= 4'd0;
				res_q.data_offset <= 12'd0;
				res_q.data_len    <= 12'd0;
				res_q.ref_count   <= 8'd0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule
`default_nettype wire

// File: sv/packet_buffer_pool_manager_unit.sv
`default_nettype none
// Packet buffer pool manager with a small and a large pool, each tracked by a
// used bitmap, and a descriptor (payload offset, length, reference count) per
// buffer. Every request yields exactly one result. A request is accepted when
// in_valid is high and in_stall is low; the front end classifies it and puts it
// in a two-entry queue. While out_valid or out_stall is low, the back end takes
// one queued request per cycle, does the lookup and the descriptor read-modify-write
// in that cycle and registers the result; a request passes the queue entry and
// then the result register before out_valid rises. The block sustains one request
// per cycle while out_stall stays low; the single descriptor read-modify-write
// sets that rate. Results wait in the output register while out_stall is high;
// the queue keeps taking requests until it is full. Descriptors of buffers that
// were never allocated are not initialized after reset; they are never reported.
module packet_buffer_pool_manager_unit
	import pbpm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  mode,
	input  wire logic        pool,
	input  wire logic [3:0]  slot,
	input  wire logic [11:0] request_len,
	input  wire logic [10:0] headroom,
	input  wire logic [11:0] shift_amount,
	input  wire logic [11:0] target_len,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic             out_pool,
	output logic [3:0]       out_slot,
	output logic [11:0]      data_offset,
	output logic [11:0]      data_len,
	output logic [7:0]       ref_count,
	output logic [3:0]       large_free
);

	cmd_t    front_cmd;
	cmd_t    head_cmd;
	q_stat_t q_stat;
	logic    push;
	logic    pop;
	res_t    res;

	// The queue refuses new requests only when both entries are taken.
	assign in_stall = q_stat.full;
	assign push     = in_valid && !q_stat.full;

	pbpm_front u_front (
		.mode         (mode),
		.pool         (pool),
		.slot         (slot),
		.request_len  (request_len),
		.headroom     (headroom),
		.shift_amount (shift_amount),
		.target_len   (target_len),
		.cmd          (front_cmd)
	);

	pbpm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (front_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.stat     (q_stat)
	);

	pbpm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (head_cmd),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.res       (res)
	);

	// Unpack the registered result onto the output ports.
	assign status      = res.status;
	assign out_pool    = res.pool;
	assign out_slot    = res.slot;
	assign data_offset = res.data_offset;
	assign data_len    = res.data_len;
	assign ref_count   = res.ref_count;
	assign large_free  = res.large_free;

endmodule
`default_nettype wire
